@@ hw/rtl/psl_pkg.sv @@
// ----------------------------------------------------------------------------
// psl_pkg
// Shared constants and codes of the priority sorted slot list.
// ----------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

	localparam int NUM_SLOTS_DEF = 32;
	localparam int SLOT_W        = 5;
	localparam int SPRI_W        = 16;
	localparam int DPRI_W        = 2;
	localparam int KEY_W         = SPRI_W + DPRI_W;
	localparam int MAX_RESULTS   = 32;
	localparam int KW            = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		OP_ADD        = 3'd0,
		OP_REMOVE     = 3'd1,
		OP_SET_PRIO   = 3'd2,
		OP_SET_HIDDEN = 3'd3,
		OP_SCAN       = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_FULL     = 2'd1,
		STS_NOT_USED = 2'd2,
		STS_EMPTY    = 2'd3
	} status_t;

endpackage

`default_nettype wire

@@ hw/rtl/priority_sorted_slot_list.sv @@
// ----------------------------------------------------------------------------
// priority_sorted_slot_list
// A pool of NUM_SLOTS slots handed out from a free-slot stack, with the live
// slots kept in a doubly linked list sorted by an 18-bit key (display priority
// over sort priority), tail holding the smallest key. Links, keys and flags
// live in one slot memory, the free stack in a second one; both have a
// registered read port. One item is worked on at a time and the slot memory's
// single read port sets the pace: hide reads and rewrites the slot, remove and
// set priority unlink it from its neighbours, add and set priority walk the list
// from the tail to find their place, and scan walks it from the tail as well,
// each result then waiting for the output register to drain. Every result
// passes through one output register.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_sorted_slot_list #(
	parameter int NUM_SLOTS = psl_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [2:0]                  opcode,
	input  wire logic [psl_pkg::SLOT_W-1:0]  slot_id,
	input  wire logic [psl_pkg::SPRI_W-1:0]  sort_priority,
	input  wire logic [psl_pkg::DPRI_W-1:0]  display_priority,
	input  wire logic                        hidden_flag,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic [psl_pkg::SLOT_W-1:0]       result_slot,
	output logic [psl_pkg::DPRI_W-1:0]       result_display_priority,
	output logic                             last_flag
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int LW = IW + 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int KEY_W = psl_pkg::KEY_W;
	localparam int KW = psl_pkg::KW;
	localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};
	localparam logic [6:0] NSLOT7 = 7'(NUM_SLOTS);

	typedef struct packed {
		logic [LW-1:0]    nxt;
		logic [LW-1:0]    prv;
		logic [KEY_W-1:0] key;
		logic             hid;
		logic             used;
	} rec_t;

	localparam int RW = $bits(rec_t);
	localparam rec_t REC_INIT = '{nxt: NIL, prv: NIL, key: '0, hid: 1'b0, used: 1'b0};

	typedef enum logic [13:0] {
		ST_IDLE    = 14'b00000000000001,
		ST_CHK     = 14'b00000000000010,
		ST_FS      = 14'b00000000000100,
		ST_U_N     = 14'b00000000001000,
		ST_U_WN    = 14'b00000000010000,
		ST_U_P     = 14'b00000000100000,
		ST_U_WP    = 14'b00000001000000,
		ST_RM      = 14'b00000010000000,
		ST_I_START = 14'b00000100000000,
		ST_I_WALK  = 14'b00001000000000,
		ST_I_WN    = 14'b00010000000000,
		ST_I_WS    = 14'b00100000000000,
		ST_SCAN    = 14'b01000000000000,
		ST_EMIT    = 14'b10000000000000
	} state_t;

	state_t state_q, state_d, unl_done;

	// control registers
	logic [CW-1:0] used_q;
	logic [LW-1:0] tail_q;
	logic [KW-1:0] k_q;
	logic          pend_v_q;
	logic          out_valid_q;

	// item and walk registers
	psl_pkg::opcode_t op_q;
	logic [IW-1:0]    sid_q;
	logic [psl_pkg::SPRI_W-1:0] sp_q;
	logic [psl_pkg::DPRI_W-1:0] dp_q;
	logic             hf_q;
	logic [IW-1:0]    s_q;
	logic [IW-1:0]    p_q;
	logic [LW-1:0]    nl_q;
	logic [LW-1:0]    pl_q;
	logic [KEY_W-1:0] key_q;
	logic             hid_q;
	logic [IW-1:0]    pend_slot_q;
	logic [psl_pkg::DPRI_W-1:0] pend_dp_q;
	psl_pkg::status_t res_status_q;
	logic [psl_pkg::SLOT_W-1:0] res_slot_q;
	logic [psl_pkg::DPRI_W-1:0] res_dp_q;
	psl_pkg::status_t out_status_q;
	logic [psl_pkg::SLOT_W-1:0] out_slot_q;
	logic [psl_pkg::DPRI_W-1:0] out_dp_q;
	logic             out_last_q;

	// memory ports
	logic          sm_re, sm_we, sm_written;
	logic [IW-1:0] sm_ra, sm_wa;
	rec_t          sm_wd;
	logic [RW-1:0] sm_rd_data;
	rec_t          srec;
	logic          fs_re, fs_we, fs_written;
	logic [IW-1:0] fs_ra, fs_wa, fs_wd, fs_rd_data, fs_val;

	// decisions
	psl_pkg::opcode_t op_in;
	logic [IW-1:0] sid_in_ix;
	logic          sid_in_ok, full, out_busy, lt, vis, scan_go, scan_more;
	logic [CW-1:0] um1;
	logic [KW-1:0] k_new;
	logic [LW-1:0] s_link, p_link;
	logic          out_load, out_last_d;
	psl_pkg::status_t out_status_d;
	logic [psl_pkg::SLOT_W-1:0] out_slot_d;
	logic [psl_pkg::DPRI_W-1:0] out_dp_d;

	psl_vram #(
		.WIDTH (RW),
		.DEPTH (NUM_SLOTS)
	) u_slot_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (sm_we),
		.wr_addr    (sm_wa),
		.wr_data    (sm_wd),
		.rd_en      (sm_re),
		.rd_addr    (sm_ra),
		.rd_data    (sm_rd_data),
		.rd_written (sm_written)
	);

	psl_vram #(
		.WIDTH (IW),
		.DEPTH (NUM_SLOTS)
	) u_free_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (fs_we),
		.wr_addr    (fs_wa),
		.wr_data    (fs_wd),
		.rd_en      (fs_re),
		.rd_addr    (fs_ra),
		.rd_data    (fs_rd_data),
		.rd_written (fs_written)
	);

	assign srec      = sm_written ? rec_t'(sm_rd_data) : REC_INIT;
	assign fs_val    = fs_written ? fs_rd_data : used_q[IW-1:0];
	assign op_in     = psl_pkg::opcode_t'(opcode);
	assign sid_in_ix = IW'(slot_id);
	assign sid_in_ok = {2'b00, slot_id} < NSLOT7;
	assign full      = (used_q == CW'(NUM_SLOTS));
	assign um1       = used_q - CW'(1);
	assign out_busy  = out_valid_q && !out_ready;
	assign s_link    = {1'b0, s_q};
	assign p_link    = {1'b0, p_q};
	assign lt        = key_q < srec.key;
	assign vis       = !srec.hid;
	assign k_new     = k_q + KW'(vis);
	assign scan_go   = !(vis && pend_v_q && out_busy);
	assign scan_more = !srec.prv[LW-1] && (k_new < KW'(psl_pkg::MAX_RESULTS));
	assign unl_done  = (op_q == psl_pkg::OP_REMOVE) ? ST_RM : ST_I_START;

	always_comb begin
		state_d      = state_q;
		sm_re        = 1'b0;
		sm_ra        = p_q;
		sm_we        = 1'b0;
		sm_wa        = p_q;
		sm_wd        = srec;
		fs_re        = 1'b0;
		fs_ra        = used_q[IW-1:0];
		fs_we        = 1'b0;
		fs_wa        = um1[IW-1:0];
		fs_wd        = sid_q;
		out_load     = 1'b0;
		out_last_d   = 1'b1;
		out_status_d = res_status_q;
		out_slot_d   = res_slot_q;
		out_dp_d     = res_dp_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op_in)
						psl_pkg::OP_ADD: begin
							if (!full) begin
								fs_re   = 1'b1;
								state_d = ST_FS;
							end else begin
								state_d = ST_EMIT;
							end
						end
						psl_pkg::OP_REMOVE, psl_pkg::OP_SET_PRIO,
						psl_pkg::OP_SET_HIDDEN: begin
							if (sid_in_ok) begin
								sm_re   = 1'b1;
								sm_ra   = sid_in_ix;
								state_d = ST_CHK;
							end else begin
								state_d = ST_EMIT;
							end
						end
						psl_pkg::OP_SCAN: begin
							if (!tail_q[LW-1]) begin
								sm_re   = 1'b1;
								sm_ra   = tail_q[IW-1:0];
								state_d = ST_SCAN;
							end else begin
								state_d = ST_EMIT;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CHK: begin
				if (!srec.used) begin
					state_d = ST_EMIT;
				end else if (op_q == psl_pkg::OP_SET_HIDDEN) begin
					sm_we     = 1'b1;
					sm_wa     = sid_q;
					sm_wd.hid = hf_q;
					state_d   = ST_EMIT;
				end else begin
					state_d = ST_U_N;
				end
			end
			ST_U_N: begin
				if (!nl_q[LW-1]) begin
					sm_re   = 1'b1;
					sm_ra   = nl_q[IW-1:0];
					state_d = ST_U_WN;
				end else begin
					state_d = ST_U_P;
				end
			end
			ST_U_WN: begin
				sm_we     = 1'b1;
				sm_wa     = nl_q[IW-1:0];
				sm_wd.prv = pl_q;
				state_d   = ST_U_P;
			end
			ST_U_P: begin
				if (!pl_q[LW-1]) begin
					sm_re   = 1'b1;
					sm_ra   = pl_q[IW-1:0];
					state_d = ST_U_WP;
				end else begin
					state_d = unl_done;
				end
			end
			ST_U_WP: begin
				sm_we     = 1'b1;
				sm_wa     = pl_q[IW-1:0];
				sm_wd.nxt = nl_q;
				state_d   = unl_done;
			end
			ST_RM: begin
				sm_we   = 1'b1;
				sm_wa   = sid_q;
				sm_wd   = REC_INIT;
				fs_we   = 1'b1;
				state_d = ST_EMIT;
			end
			ST_FS: begin
				state_d = ST_I_START;
			end
			ST_I_START: begin
				if (!tail_q[LW-1]) begin
					sm_re   = 1'b1;
					sm_ra   = tail_q[IW-1:0];
					state_d = ST_I_WALK;
				end else begin
					state_d = ST_I_WS;
				end
			end
			ST_I_WALK: begin
				if (lt) begin
					sm_we     = 1'b1;
					sm_wd.nxt = s_link;
					if (!srec.nxt[LW-1]) begin
						sm_re   = 1'b1;
						sm_ra   = srec.nxt[IW-1:0];
						state_d = ST_I_WN;
					end else begin
						state_d = ST_I_WS;
					end
				end else if (srec.prv[LW-1]) begin
					sm_we     = 1'b1;
					sm_wd.prv = s_link;
					state_d   = ST_I_WS;
				end else begin
					sm_re = 1'b1;
					sm_ra = srec.prv[IW-1:0];
				end
			end
			ST_I_WN: begin
				sm_we     = 1'b1;
				sm_wa     = nl_q[IW-1:0];
				sm_wd.prv = s_link;
				state_d   = ST_I_WS;
			end
			ST_I_WS: begin
				sm_we   = 1'b1;
				sm_wa   = s_q;
				sm_wd   = '{nxt: nl_q, prv: pl_q, key: key_q, hid: hid_q, used: 1'b1};
				state_d = ST_EMIT;
			end
			ST_SCAN: begin
				if (scan_go) begin
					if (vis && pend_v_q) begin
						out_load     = 1'b1;
						out_last_d   = 1'b0;
						out_status_d = psl_pkg::STS_OK;
						out_slot_d   = psl_pkg::SLOT_W'(pend_slot_q);
						out_dp_d     = pend_dp_q;
					end
					if (scan_more) begin
						sm_re = 1'b1;
						sm_ra = srec.prv[IW-1:0];
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (!out_busy) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			tail_q      <= NIL;
			k_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					k_q      <= '0;
					pend_v_q <= 1'b0;
				end
				ST_FS: begin
					used_q <= used_q + CW'(1);
				end
				ST_RM: begin
					used_q <= um1;
				end
				ST_U_N: begin
					if (nl_q[LW-1]) begin
						tail_q <= pl_q;
					end
				end
				ST_I_START: begin
					if (tail_q[LW-1]) begin
						tail_q <= s_link;
					end
				end
				ST_I_WALK: begin
					if (lt && tail_q == p_link) begin
						tail_q <= s_link;
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						k_q <= k_new;
						if (vis) begin
							pend_v_q <= 1'b1;
						end
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_slot_q   <= out_slot_d;
			out_dp_q     <= out_dp_d;
			out_last_q   <= out_last_d;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q       <= op_in;
					sid_q      <= sid_in_ix;
					sp_q       <= sort_priority;
					dp_q       <= display_priority;
					hf_q       <= hidden_flag;
					p_q        <= tail_q[IW-1:0];
					res_slot_q <= '0;
					res_dp_q   <= '0;
					if (op_in == psl_pkg::OP_ADD && full) begin
						res_status_q <= psl_pkg::STS_FULL;
					end else if ((op_in == psl_pkg::OP_REMOVE ||
						op_in == psl_pkg::OP_SET_PRIO ||
						op_in == psl_pkg::OP_SET_HIDDEN) && !sid_in_ok) begin
						res_status_q <= psl_pkg::STS_NOT_USED;
					end else if (op_in == psl_pkg::OP_SCAN && tail_q[LW-1]) begin
						res_status_q <= psl_pkg::STS_EMPTY;
					end else begin
						res_status_q <= psl_pkg::STS_OK;
					end
				end
			end
			ST_CHK: begin
				if (!srec.used) begin
					res_status_q <= psl_pkg::STS_NOT_USED;
				end
				nl_q  <= srec.nxt;
				pl_q  <= srec.prv;
				key_q <= {srec.key[KEY_W-1:psl_pkg::SPRI_W], sp_q};
				hid_q <= srec.hid;
				s_q   <= sid_q;
			end
			ST_FS: begin
				s_q        <= fs_val;
				key_q      <= {dp_q, sp_q};
				hid_q      <= 1'b0;
				res_slot_q <= psl_pkg::SLOT_W'(fs_val);
			end
			ST_I_START: begin
				if (tail_q[LW-1]) begin
					nl_q <= NIL;
					pl_q <= NIL;
				end else begin
					p_q <= tail_q[IW-1:0];
				end
			end
			ST_I_WALK: begin
				if (lt) begin
					nl_q <= srec.nxt;
					pl_q <= p_link;
				end else if (srec.prv[LW-1]) begin
					nl_q <= p_link;
					pl_q <= NIL;
				end else begin
					p_q <= srec.prv[IW-1:0];
				end
			end
			ST_SCAN: begin
				if (scan_go) begin
					if (vis) begin
						pend_slot_q <= p_q;
						pend_dp_q   <= srec.key[KEY_W-1:psl_pkg::SPRI_W];
					end
					if (scan_more) begin
						p_q <= srec.prv[IW-1:0];
					end else begin
						res_status_q <= (vis || pend_v_q) ? psl_pkg::STS_OK
							: psl_pkg::STS_EMPTY;
						res_slot_q <= vis ? psl_pkg::SLOT_W'(p_q)
							: pend_v_q ? psl_pkg::SLOT_W'(pend_slot_q) : '0;
						res_dp_q <= vis ? srec.key[KEY_W-1:psl_pkg::SPRI_W]
							: pend_v_q ? pend_dp_q : '0;
					end
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign in_ready                = (state_q == ST_IDLE);
	assign out_valid               = out_valid_q;
	assign status                  = out_status_q;
	assign result_slot             = out_slot_q;
	assign result_display_priority = out_dp_q;
	assign last_flag               = out_last_q;

	a_walk_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_I_WALK) |-> srec.used)
		else $error("insertion walk reached a free slot");

	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> srec.used)
		else $error("scan reached a free slot");

	a_tail_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (tail_q[LW-1] == (used_q == '0)))
		else $error("tail and used count disagree");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (k_q < KW'(psl_pkg::MAX_RESULTS)))
		else $error("scan ran past its result limit");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FS) |-> (used_q < CW'(NUM_SLOTS)))
		else $error("slot taken from an empty free stack");

endmodule

`default_nettype wire

@@ hw/rtl/psl_ram.sv @@
// ----------------------------------------------------------------------------
// psl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/psl_vram.sv @@
// ----------------------------------------------------------------------------
// psl_vram
// RAM with a written bit per entry, returned with each read, so that the user can
// treat unwritten entries as their reset value without a clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_vram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  rd_written
);

	logic [DEPTH-1:0] written_q;
	logic             rd_written_q;

	psl_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_written = rd_written_q;

endmodule

`default_nettype wire
